/* src/ukvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukvt_pkg
// Shared sizes, codes and types of the unsorted key/value table.
// ----------------------------------------------------------------------------
package ukvt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Per-cell controls produced by the top level for one request.
  typedef struct packed {
    logic match_en;
    logic write_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

/* src/unsorted_key_value_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_key_value_table_top
// Key/value table of DEPTH rows in insertion order with insert, lookup and
// erase, built as a chain of row cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (operation, key, value) is taken when in_valid and in_ready are
//   both high. Insert appends a row, lookup returns the value of the earliest
//   row with the key, erase removes that row and moves later rows down.
//   Each request gives one result (status, found, found_value, row_count,
//   empty_res), handed over when out_valid and out_ready are both high.
//   The result is valid in the cycle after the request is taken. All rows
//   compare in parallel and the hit flag ripples through the cell chain in
//   the same cycle, so one request is taken every cycle unless a result waits.
//   The result register is the only buffer: while a result waits, in_ready
//   stays high only if out_ready is high in that cycle, so a stalled receiver
//   stops the input side after one result.
//   Reset empties the table (row count zero) and clears out_valid; rows are
//   not cleared, since rows at or above the count are never read.
// ----------------------------------------------------------------------------
module unsorted_key_value_table_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        operation,
  input  logic [ukvt_pkg::KEY_WIDTH-1:0]    key,
  input  logic [ukvt_pkg::VALUE_WIDTH-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic                              found,
  output logic [ukvt_pkg::VALUE_WIDTH-1:0]  found_value,
  output logic [ukvt_pkg::COUNT_WIDTH-1:0]  row_count,
  output logic                              empty_res
);

  localparam int D  = ukvt_pkg::DEPTH;
  localparam int CW = ukvt_pkg::COUNT_WIDTH;

  ukvt_pkg::op_t                    op;
  logic                             accept;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic                             full;
  logic                             hit;
  logic [ukvt_pkg::VALUE_WIDTH-1:0] lookup_value;
  ukvt_pkg::status_t                status_next;
  logic [ukvt_pkg::VALUE_WIDTH-1:0] found_value_next;

  ukvt_pkg::cell_ctrl_t             ctrl       [D];
  logic [D:0]                       hit_chain;
  logic [ukvt_pkg::KEY_WIDTH-1:0]   cell_key   [D];
  logic [ukvt_pkg::VALUE_WIDTH-1:0] cell_value [D];
  logic [ukvt_pkg::VALUE_WIDTH-1:0] hit_values [D];

  assign op       = ukvt_pkg::op_t'(operation);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(D));

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign ctrl[i].match_en = accept && (op == ukvt_pkg::OP_LOOKUP ||
                                         op == ukvt_pkg::OP_ERASE) &&
                              (CW'(i) < count);
    assign ctrl[i].write_en = accept && (op == ukvt_pkg::OP_INSERT) &&
                              (CW'(i) == count);
    assign ctrl[i].shift_en = accept && (op == ukvt_pkg::OP_ERASE);

    if (i == D - 1) begin : g_top_row
      // The last row has no upper neighbor; its content after an erase is
      // beyond the count and never read.
      ukvt_cell u_cell (
        .clk           (clk),
        .ctrl          (ctrl[i]),
        .req_key       (key),
        .req_value     (value),
        .upper_key     (cell_key[i]),
        .upper_value   (cell_value[i]),
        .hit_in        (hit_chain[i]),
        .hit_out       (hit_chain[i+1]),
        .row_key_out   (cell_key[i]),
        .row_value_out (cell_value[i]),
        .hit_value     (hit_values[i])
      );
    end else begin : g_row
      ukvt_cell u_cell (
        .clk           (clk),
        .ctrl          (ctrl[i]),
        .req_key       (key),
        .req_value     (value),
        .upper_key     (cell_key[i+1]),
        .upper_value   (cell_value[i+1]),
        .hit_in        (hit_chain[i]),
        .hit_out       (hit_chain[i+1]),
        .row_key_out   (cell_key[i]),
        .row_value_out (cell_value[i]),
        .hit_value     (hit_values[i])
      );
    end
  end

  assign hit = hit_chain[D];

  always_comb begin
    lookup_value = '0;
    for (int i = 0; i < D; i++) begin
      lookup_value = lookup_value | hit_values[i];
    end
  end

  always_comb begin
    count_next       = count;
    status_next      = ukvt_pkg::ST_OK;
    found_value_next = '0;
    unique case (op)
      ukvt_pkg::OP_INSERT: begin
        if (full) begin
          status_next = ukvt_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ukvt_pkg::OP_LOOKUP: begin
        if (hit) begin
          found_value_next = lookup_value;
        end else begin
          status_next = ukvt_pkg::ST_MISS;
        end
      end
      ukvt_pkg::OP_ERASE: begin
        if (hit) begin
          count_next = count - CW'(1);
        end else begin
          status_next = ukvt_pkg::ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      found       <= hit;
      found_value <= found_value_next;
      row_count   <= count_next;
      empty_res   <= (count_next == '0);
    end
  end

endmodule

/* src/ukvt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukvt_cell
// One row of the table: holds a key and a value, compares against the request
// key, passes the running hit flag up the chain and takes its upper
// neighbor's row when an erase closes the gap.
// ----------------------------------------------------------------------------
module ukvt_cell (
  input  logic                              clk,
  input  ukvt_pkg::cell_ctrl_t              ctrl,
  input  logic [ukvt_pkg::KEY_WIDTH-1:0]    req_key,
  input  logic [ukvt_pkg::VALUE_WIDTH-1:0]  req_value,
  input  logic [ukvt_pkg::KEY_WIDTH-1:0]    upper_key,
  input  logic [ukvt_pkg::VALUE_WIDTH-1:0]  upper_value,
  input  logic                              hit_in,
  output logic                              hit_out,
  output logic [ukvt_pkg::KEY_WIDTH-1:0]    row_key_out,
  output logic [ukvt_pkg::VALUE_WIDTH-1:0]  row_value_out,
  output logic [ukvt_pkg::VALUE_WIDTH-1:0]  hit_value
);

  logic [ukvt_pkg::KEY_WIDTH-1:0]   row_key;
  logic [ukvt_pkg::KEY_WIDTH-1:0]   row_key_next;
  logic [ukvt_pkg::VALUE_WIDTH-1:0] row_value;
  logic [ukvt_pkg::VALUE_WIDTH-1:0] row_value_next;
  logic                             match;

  assign match   = ctrl.match_en && (row_key == req_key);
  assign hit_out = hit_in || match;

  // Only the earliest matching row drives its value; all others give zero.
  assign hit_value = (match && !hit_in) ? row_value : '0;

  assign row_key_out   = row_key;
  assign row_value_out = row_value;

  always_comb begin
    row_key_next   = row_key;
    row_value_next = row_value;
    if (ctrl.write_en) begin
      row_key_next   = req_key;
      row_value_next = req_value;
    end else if (ctrl.shift_en && hit_out) begin
      // This row or one below it is erased, so every row from here moves down.
      row_key_next   = upper_key;
      row_value_next = upper_value;
    end
  end

  always_ff @(posedge clk) begin
    row_key   <= row_key_next;
    row_value <= row_value_next;
  end

endmodule
